[rtl/arp_cache_table_assert.svh]
// assertion macros shared by the arp cache rtl
`ifndef ARP_CACHE_TABLE_ASSERT_SVH
`define ARP_CACHE_TABLE_ASSERT_SVH

// checked on every clock edge outside reset
`define ARPC_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ARPC_ASSERT_ALL(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/arpc_pkg.sv]
// shared types and constants of the arp cache
package arpc_pkg;

   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int INDEX_W = 3;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_ADD    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic latch;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctrl_sts_type;

endpackage

[rtl/arpc_if.sv]
// request and response channel interfaces of the arp cache
interface arpc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [arpc_pkg::IP_W-1:0]   ip_addr;
   logic [arpc_pkg::MAC_W-1:0]  mac_addr;

   modport source (output valid, output func, output ip_addr, output mac_addr, input ready);
   modport sink   (input valid, input func, input ip_addr, input mac_addr, output ready);
endinterface

interface arpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [arpc_pkg::MAC_W-1:0]    mac_out;
   logic [arpc_pkg::INDEX_W-1:0]  entry_index;

   modport source (output valid, output hit, output mac_out, output entry_index, input ready);
   modport sink   (input valid, input hit, input mac_out, input entry_index, output ready);
endinterface

[rtl/arpc_ram.sv]
// generic simple dual port ram with registered read
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/arpc_dpath.sv]
// datapath of the arp cache: request registers, scan pipeline, entry store, result registers
module arpc_dpath #(
   parameter int ENTRIES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  arpc_pkg::ctrl_cmd_type           cmd,
   output arpc_pkg::ctrl_sts_type           sts,
   input  logic                             req_func,
   input  logic [arpc_pkg::IP_W-1:0]        req_ip_addr,
   input  logic [arpc_pkg::MAC_W-1:0]       req_mac_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]       rsp_mac_out,
   output logic [arpc_pkg::INDEX_W-1:0]     rsp_entry_index
);
   import arpc_pkg::*;

   `include "arp_cache_table_assert.svh"

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_W = IP_W + MAC_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   logic               req_func_ff;
   logic [IP_W-1:0]    req_ip_ff;
   logic [MAC_W-1:0]   req_mac_ff;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               cmp_live_ff, cmp_live_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               pend_hit_ff;
   logic [MAC_W-1:0]   pend_mac_ff;
   logic [IDX_W-1:0]   pend_slot_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [MAC_W-1:0]   rsp_mac_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic [IP_W-1:0]    rd_ip;
   logic [MAC_W-1:0]   rd_mac;
   logic               ip_eq;
   logic               ent_valid;
   logic               sel;
   logic               found;
   logic               at_end;
   logic               wr_en;
   logic               is_add;

   arpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pend_slot_ff),
      .wr_data ({req_ip_ff, req_mac_ff}),
      .rd_en   (cmd.step),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_ip     = rd_data[ENTRY_W-1 -: IP_W];
   assign rd_mac    = rd_data[MAC_W-1:0];
   assign is_add    = (req_func_ff == FUNC_ADD);
   assign ip_eq     = (rd_ip == req_ip_ff);
   assign ent_valid = valid_ff[cmp_idx_ff];
   // add takes an empty entry or one with the same address, lookup needs a valid match
   assign sel       = is_add ? (!ent_valid || ip_eq) : (ent_valid && ip_eq);
   assign found     = cmp_live_ff && sel;
   assign at_end    = cmp_live_ff && (cmp_idx_ff == LAST);
   assign wr_en     = cmd.emit && is_add;

   assign sts.scan_done = found || at_end;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      cmp_live_in  = cmp_live_ff;
      cmp_idx_in   = cmp_idx_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         cmp_live_in  = 1'b0;
      end else if (cmd.step) begin
         cmp_live_in = 1'b1;
         cmp_idx_in  = scan_addr_ff;
         if (scan_addr_ff != LAST) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[pend_slot_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_live_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_live_ff  <= cmp_live_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      if (cmd.load) begin
         req_func_ff <= req_func;
         req_ip_ff   <= req_ip_addr;
         req_mac_ff  <= req_mac_addr;
      end
      if (cmd.latch) begin
         pend_hit_ff  <= found || is_add;
         pend_slot_ff <= found ? cmp_idx_ff : '0;
         pend_mac_ff  <= (found && !is_add) ? rd_mac : '0;
      end
      if (cmd.emit) begin
         rsp_hit_ff   <= pend_hit_ff;
         rsp_mac_ff   <= pend_mac_ff;
         rsp_index_ff <= INDEX_W'(pend_slot_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_mac_out     = rsp_mac_ff;
   assign rsp_entry_index = rsp_index_ff;

   `ARPC_ASSERT_RST(a_emit_free, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_ready), "emit over a pending response")
   `ARPC_ASSERT_RST(a_add_valid, clock, reset, wr_en |=> valid_ff[$past(pend_slot_ff)], "added entry not marked valid")
   `ARPC_ASSERT_RST(a_cmp_range, clock, reset, cmp_live_ff |-> (cmp_idx_ff <= LAST), "scan index past last entry")

endmodule

[rtl/arpc_ctrl.sv]
// controller state machine of the arp cache
module arpc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output arpc_pkg::ctrl_cmd_type  cmd,
   input  arpc_pkg::ctrl_sts_type  sts
);
   import arpc_pkg::*;

   `include "arp_cache_table_assert.svh"

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.step  = 1'b1;
            cmd.latch = sts.scan_done;
         end
         ST_WAIT: begin
            cmd.emit = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ARPC_ASSERT_RST(a_wait_entry, clock, reset, (state_ff == ST_WAIT) |-> $past(state_ff == ST_SCAN || state_ff == ST_WAIT), "wait entered without a scan")

endmodule

[rtl/arp_cache_table.sv]
// top level of the arp cache: ipv4 address to mac address table
//
// usage
//   req_ch carries one transaction per operation: func selects lookup (0) or
//   add/update (1), with ip_addr and, for an add, mac_addr
//   rsp_ch returns exactly one transaction per request: hit, mac_out and
//   entry_index, in request order
//   a request is taken only while the block is idle; entries are scanned one
//   per cycle through a single read port of the entry store
//   the scan stops at the first entry that fits or runs to the last entry;
//   an add takes the first empty entry or one with the same address and,
//   when none fits, overwrites entry 0; the result is latched, then handed
//   to the output register once rsp_ch can take it
//   the response sits in an output register; the next request is accepted
//   and scanned while it waits, and only its final hand-off stalls on rsp_ch
//   reset clears all valid bits, the pending response and the controller;
//   address and mac storage is not cleared and needs no clearing pass
module arp_cache_table #(
   parameter int ENTRIES = 8
) (
   input  logic              clock,
   input  logic              reset,
   arpc_req_if.sink          req_ch,
   arpc_rsp_if.source        rsp_ch
);
   import arpc_pkg::*;

   // command and status between controller and datapath
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // controller: idle, scan the entries, hand the result to the output register
   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: request capture, pipelined scan of the store, result registers
   arpc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_ch.func),
      .req_ip_addr     (req_ch.ip_addr),
      .req_mac_addr    (req_ch.mac_addr),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_hit         (rsp_ch.hit),
      .rsp_mac_out     (rsp_ch.mac_out),
      .rsp_entry_index (rsp_ch.entry_index)
   );

endmodule
